@@ sv/pcrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrt_pkg
// Shared types and constants of the per-channel request throttle.
// ----------------------------------------------------------------------------
package pcrt_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int CHAN_W  = 31;
  localparam int CODE_W  = 16;
  localparam int TIME_W  = 54;
  localparam int DELAY_W = 32;
  localparam int THR_W   = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 3;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [DELAY_W-1:0] DEFAULT_DELAY_RST = 32'd1500000;
  localparam logic [DELAY_W-1:0] LONG_DELAY_RST    = 32'd10000000;
  localparam logic [DELAY_W-1:0] RESET_WINDOW_RST  = 32'd10000000;
  localparam logic [THR_W-1:0]   DIM_THR_RST       = 8'd20;
  localparam logic [THR_W-1:0]   NORM_THR_RST      = 8'd5;
  localparam logic [CODE_W-1:0]  DIMMER_CODE_RST   = 16'd180;
  localparam logic [CODE_W-1:0]  RGB_CODE_RST      = 16'd190;
  localparam logic [CODE_W-1:0]  DIM_RGB_CODE_RST  = 16'd200;

  localparam logic [THR_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_DEFAULT_DELAY = 3'd0,
    CFG_LONG_DELAY    = 3'd1,
    CFG_RESET_WINDOW  = 3'd2,
    CFG_DIM_THR       = 3'd3,
    CFG_NORM_THR      = 3'd4,
    CFG_DIMMER_CODE   = 3'd5,
    CFG_RGB_CODE      = 3'd6,
    CFG_DIM_RGB_CODE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0] default_delay_us;
    logic [DELAY_W-1:0] long_delay_us;
    logic [DELAY_W-1:0] reset_window_us;
    logic [THR_W-1:0]   dimming_threshold;
    logic [THR_W-1:0]   normal_threshold;
    logic [CODE_W-1:0]  dimmer_code;
    logic [CODE_W-1:0]  rgb_code;
    logic [CODE_W-1:0]  dimmer_rgb_code;
  } cfg_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [THR_W-1:0]  cnt;
    logic [TIME_W-1:0] last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GAP,
    ST_DECIDE,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

@@ sv/pcrt_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrt_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pcrt_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pcrt_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [pcrt_pkg::CFG_W-1:0]    cfg_wdata,
  output pcrt_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_delay_us  <= pcrt_pkg::DEFAULT_DELAY_RST;
      cfg.long_delay_us     <= pcrt_pkg::LONG_DELAY_RST;
      cfg.reset_window_us   <= pcrt_pkg::RESET_WINDOW_RST;
      cfg.dimming_threshold <= pcrt_pkg::DIM_THR_RST;
      cfg.normal_threshold  <= pcrt_pkg::NORM_THR_RST;
      cfg.dimmer_code       <= pcrt_pkg::DIMMER_CODE_RST;
      cfg.rgb_code          <= pcrt_pkg::RGB_CODE_RST;
      cfg.dimmer_rgb_code   <= pcrt_pkg::DIM_RGB_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcrt_pkg::CFG_DEFAULT_DELAY: cfg.default_delay_us  <= cfg_wdata;
        pcrt_pkg::CFG_LONG_DELAY:    cfg.long_delay_us     <= cfg_wdata;
        pcrt_pkg::CFG_RESET_WINDOW:  cfg.reset_window_us   <= cfg_wdata;
        pcrt_pkg::CFG_DIM_THR:       cfg.dimming_threshold <= cfg_wdata[pcrt_pkg::THR_W-1:0];
        pcrt_pkg::CFG_NORM_THR:      cfg.normal_threshold  <= cfg_wdata[pcrt_pkg::THR_W-1:0];
        pcrt_pkg::CFG_DIMMER_CODE:   cfg.dimmer_code       <= cfg_wdata[pcrt_pkg::CODE_W-1:0];
        pcrt_pkg::CFG_RGB_CODE:      cfg.rgb_code          <= cfg_wdata[pcrt_pkg::CODE_W-1:0];
        pcrt_pkg::CFG_DIM_RGB_CODE:  cfg.dimmer_rgb_code   <= cfg_wdata[pcrt_pkg::CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/pcrt_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrt_table
// Channel table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcrt_table #(
  parameter int ENTRIES = pcrt_pkg::ENTRIES_DEF,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] rd_addr,
  output pcrt_pkg::entry_t      rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  pcrt_pkg::entry_t      wr_data
);

  pcrt_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ sv/pcrt_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrt_seq
// Sequencer: table scan with one shared channel comparator, gap check,
// threshold decision, table write-back and the output register.
// ----------------------------------------------------------------------------
module pcrt_seq #(
  parameter int ENTRIES = pcrt_pkg::ENTRIES_DEF,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES) + 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  pcrt_pkg::cfg_t                       cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pcrt_pkg::CHAN_W-1:0]     in_chan,
  input  wire logic [pcrt_pkg::CODE_W-1:0]     in_code,
  input  wire logic [pcrt_pkg::TIME_W-1:0]     in_now,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [pcrt_pkg::DELAY_W-1:0]         out_delay,
  output logic                                 out_over,
  output logic                                 out_full,
  output logic [IDX_W-1:0]                     rd_addr,
  input  pcrt_pkg::entry_t                     rd_data,
  output logic                                 wr_en,
  output logic [IDX_W-1:0]                     wr_addr,
  output pcrt_pkg::entry_t                     wr_data
);

  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  pcrt_pkg::state_t state, state_next;

  logic [CNT_W-1:0]             used;
  logic [CNT_W-1:0]             idx;
  logic                         pend;
  logic [IDX_W-1:0]             pend_idx;
  logic [IDX_W-1:0]             slot;
  logic [pcrt_pkg::CHAN_W-1:0]  chan_r;
  logic [pcrt_pkg::CODE_W-1:0]  code_r;
  logic [pcrt_pkg::TIME_W-1:0]  now_r;
  logic [pcrt_pkg::THR_W-1:0]   ent_cnt;
  logic [pcrt_pkg::TIME_W-1:0]  ent_last;
  logic [pcrt_pkg::THR_W-1:0]   new_cnt;
  logic                         clear_r;
  logic [pcrt_pkg::DELAY_W-1:0] res_delay;
  logic                         res_over;
  logic                         res_full;

  logic                         accept;
  logic                         bypass;
  logic                         issue;
  logic                         hit;
  logic                         fin_load;
  logic [pcrt_pkg::TIME_W:0]    gap_diff;
  logic                         gap_clear;
  logic                         dim_code;
  logic [pcrt_pkg::THR_W-1:0]   thr;
  logic                         over_now;

  always_comb begin
    accept    = in_valid && in_ready;
    bypass    = cfg.default_delay_us >= cfg.reset_window_us;
    issue     = idx < used;
    hit       = pend && (rd_data.chan == chan_r);
    fin_load  = (state == pcrt_pkg::ST_FIN) && (!out_valid || out_ready);
    gap_diff  = {1'b0, now_r} - {1'b0, ent_last};
    gap_clear = $signed(gap_diff) >=
                $signed({{(pcrt_pkg::TIME_W + 1 - pcrt_pkg::DELAY_W){1'b0}},
                         cfg.reset_window_us});
    dim_code  = (code_r == cfg.dimmer_code) || (code_r == cfg.rgb_code) ||
                (code_r == cfg.dimmer_rgb_code);
    thr       = dim_code ? cfg.dimming_threshold : cfg.normal_threshold;
    over_now  = !clear_r && (new_cnt >= thr);
    rd_addr   = idx[IDX_W-1:0];
    wr_en     = state == pcrt_pkg::ST_DECIDE;
    wr_addr   = slot;
    wr_data.chan = chan_r;
    wr_data.cnt  = clear_r ? '0 : new_cnt;
    wr_data.last = now_r;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      pcrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = bypass ? pcrt_pkg::ST_FIN : pcrt_pkg::ST_SCAN;
        end
      end
      pcrt_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = pcrt_pkg::ST_GAP;
        end else if (!issue) begin
          state_next = (used < ENTRIES_C) ? pcrt_pkg::ST_GAP : pcrt_pkg::ST_FIN;
        end
      end
      pcrt_pkg::ST_GAP:    state_next = pcrt_pkg::ST_DECIDE;
      pcrt_pkg::ST_DECIDE: state_next = pcrt_pkg::ST_FIN;
      pcrt_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = pcrt_pkg::ST_IDLE;
        end
      end
      default: state_next = pcrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcrt_pkg::ST_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == pcrt_pkg::ST_IDLE) begin
        pend <= 1'b0;
      end else if (state == pcrt_pkg::ST_SCAN) begin
        pend <= issue && !hit;
        if (!hit && !issue && (used < ENTRIES_C)) begin
          used <= used + 1'b1;
        end
      end
    end
  end

  // Datapath registers; control state above carries the reset.
  always_ff @(posedge clk) begin
    case (state)
      pcrt_pkg::ST_IDLE: begin
        idx       <= '0;
        chan_r    <= in_chan;
        code_r    <= in_code;
        now_r     <= in_now;
        res_delay <= cfg.default_delay_us;
        res_over  <= 1'b0;
        res_full  <= 1'b0;
      end
      pcrt_pkg::ST_SCAN: begin
        if (hit) begin
          slot     <= pend_idx;
          ent_cnt  <= rd_data.cnt;
          ent_last <= rd_data.last;
        end else if (issue) begin
          pend_idx <= idx[IDX_W-1:0];
          idx      <= idx + 1'b1;
        end else if (used < ENTRIES_C) begin
          // New channel: fresh entry with count zero and last time now.
          slot     <= used[IDX_W-1:0];
          ent_cnt  <= '0;
          ent_last <= now_r;
        end else begin
          res_full <= 1'b1;
        end
      end
      pcrt_pkg::ST_GAP: begin
        new_cnt <= (ent_cnt == pcrt_pkg::CNT_MAX) ? ent_cnt : ent_cnt + 1'b1;
        clear_r <= gap_clear;
      end
      pcrt_pkg::ST_DECIDE: begin
        res_over <= over_now;
        if (over_now) begin
          res_delay <= cfg.long_delay_us;
        end
      end
      default: begin
      end
    endcase
    if (fin_load) begin
      out_delay <= res_delay;
      out_over  <= res_over;
      out_full  <= res_full;
    end
  end

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= ENTRIES_C)
    else $error("fill count beyond table size");

  // A result never carries both flags.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_over && out_full))
    else $error("long delay and full flag together");

  // A hit only comes from a filled entry.
  a_hit_filled: assert property (@(posedge clk) disable iff (rst)
    (state == pcrt_pkg::ST_SCAN && hit) |-> ({1'b0, pend_idx} < used))
    else $error("hit on an unfilled entry");

  // With the default not below the window, the table is skipped.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (accept && bypass) |=> (state == pcrt_pkg::ST_FIN))
    else $error("bypass request went to the table");

endmodule
`default_nettype wire

@@ sv/per_channel_request_throttle_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_request_throttle_core
// Per-channel request throttle: answers each request with a delay.
// ----------------------------------------------------------------------------
// A request transfer on the s_axis channel carries a channel id, a function
// code and the current time in microseconds. The block answers each request
// with exactly one transfer on the m_axis channel holding the delay and two
// flags. The channel table is scanned one entry per cycle through a single
// memory read port and one shared channel comparator.
// The scan stops at the first entry that holds the request's channel. A miss
// takes a free entry when there is one; on a full table the result carries
// the full flag and the table is not written. When the default delay is not
// below the reset window the table is skipped.
// One request is processed at a time: s_axis_tready is high only while the
// block is idle, so the next request is taken only once the last is done.
// The result sits in an output register; a new request is taken while it
// waits, and a stalled receiver only holds the block when the next result is
// finished and the register is still full.
// Reset (rst, synchronous) empties the table by clearing its fill count and
// loads the register defaults. Configuration writes belong in idle periods.
// ----------------------------------------------------------------------------
module per_channel_request_throttle_core #(
  parameter int ENTRIES = pcrt_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [pcrt_pkg::CFG_A_W-1:0]        cfg_addr,
  input  wire logic [pcrt_pkg::CFG_W-1:0]          cfg_wdata,
  // Requests.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // chan_num [30:0], func_code [46:31], now_us [100:47], zero [103:101]
  input  wire logic [pcrt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Results.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // delay_us [31:0], over_threshold [32], table_full [33], zero [39:34]
  output logic [pcrt_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);

  pcrt_pkg::cfg_t   cfg;
  pcrt_pkg::entry_t rd_data;
  pcrt_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  logic [pcrt_pkg::DELAY_W-1:0] out_delay;
  logic                         out_over;
  logic                         out_full;

  pcrt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcrt_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Request fields unpacked from the lowest bit up.
  pcrt_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_chan   (s_axis_tdata[30:0]),
    .in_code   (s_axis_tdata[46:31]),
    .in_now    (s_axis_tdata[100:47]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_delay (out_delay),
    .out_over  (out_over),
    .out_full  (out_full),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign m_axis_tdata = {6'd0, out_full, out_over, out_delay};

endmodule
`default_nettype wire
